/* rtl/timestamp_ordered_event_buffer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the timestamp-ordered event buffer
// Concurrent assertion shorthands clocked on i_clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_ORDERED_EVENT_BUFFER_ASSERT_SVH
`define TIMESTAMP_ORDERED_EVENT_BUFFER_ASSERT_SVH

// Same-cycle implication
`define TOEB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("toeb assertion failed");

// Next-cycle implication
`define TOEB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("toeb assertion failed");

`endif

/* rtl/toeb_pkg.sv */
// ----------------------------------------------------------------------------
// toeb_pkg
// Shared types and constants of the timestamp-ordered event buffer.
// ----------------------------------------------------------------------------
package toeb_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int TIME_W    = 48;
    localparam int PAY_W     = 32;
    localparam int CFG_IDX_W = 2;

    // operation codes of an input word
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_EN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_ALL = 2'd1;

    typedef enum logic [1:0] {
        ST_DRAINED = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic insert;
        logic load_reject;
        logic load_empty;
        logic capture;
        logic pop;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic trace_en;
        logic head_ok;
        logic next_ok;
        logic out_free;
    } t_stat;

endpackage

/* rtl/toeb_in_if.sv */
// ----------------------------------------------------------------------------
// toeb_in_if
// Input channel: insert and dump words.
// ----------------------------------------------------------------------------
interface toeb_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [47:0] event_time;
    logic [31:0] event_payload;
    logic        force_all;
    logic [47:0] dump_limit;

    modport source (output valid, op, event_time, event_payload, force_all, dump_limit,
                    input ready);
    modport sink   (input valid, op, event_time, event_payload, force_all, dump_limit,
                    output ready);
endinterface

/* rtl/toeb_out_if.sv */
// ----------------------------------------------------------------------------
// toeb_out_if
// Result channel: drained events and status words.
// ----------------------------------------------------------------------------
interface toeb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] out_payload;
    logic [47:0] out_time;
    logic        last;

    modport source (output valid, status, out_payload, out_time, last, input ready);
    modport sink   (input valid, status, out_payload, out_time, last, output ready);
endinterface

/* rtl/toeb_cfg_if.sv */
// ----------------------------------------------------------------------------
// toeb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface toeb_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/toeb_datapath.sv */
// ----------------------------------------------------------------------------
// toeb_datapath
// Sorted shift-register cells, fill count, dump context and result register.
// ----------------------------------------------------------------------------
module toeb_datapath
    import toeb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [TIME_W-1:0]    i_event_time,
    input  logic [PAY_W-1:0]     i_event_payload,
    input  logic                 i_force_all,
    input  logic [TIME_W-1:0]    i_dump_limit,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [1:0]           o_status,
    output logic [PAY_W-1:0]     o_out_payload,
    output logic [TIME_W-1:0]    o_out_time,
    output logic                 o_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [TIME_W-1:0] r_time [DEPTH];
    logic [PAY_W-1:0]  r_pay  [DEPTH];
    logic [TIME_W-1:0] n_time [DEPTH];
    logic [PAY_W-1:0]  n_pay  [DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [DEPTH-1:0]  w_gt;

    logic              r_trace_en;
    logic              r_drain_all;
    logic              r_all;
    logic [TIME_W-1:0] r_limit;

    logic              r_out_valid;
    t_status           r_status;
    logic [PAY_W-1:0]  r_out_pay;
    logic [TIME_W-1:0] r_out_time;
    logic              r_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace_en  <= 1'b1;
            r_drain_all <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TRACE_EN)  r_trace_en  <= i_cfg_data;
            if (i_cfg_index == CFG_DRAIN_ALL) r_drain_all <= i_cfg_data;
        end
    end

    // stored entries later than the new timestamp (monotone over the cells)
    for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
        assign w_gt[i] = (CNT_W'(i) < r_count) && (r_time[i] > i_event_time);
    end

    // cells: insert opens a slot at the first later entry, pop shifts to head
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic              w_from_prev;
        logic              w_take_new;
        logic [TIME_W-1:0] w_prev_time;
        logic [PAY_W-1:0]  w_prev_pay;
        logic [TIME_W-1:0] w_next_time;
        logic [PAY_W-1:0]  w_next_pay;
        if (i == 0) begin : g_head
            assign w_from_prev = 1'b0;
            assign w_prev_time = '0;
            assign w_prev_pay  = '0;
        end else begin : g_body
            assign w_from_prev = w_gt[i-1];
            assign w_prev_time = r_time[i-1];
            assign w_prev_pay  = r_pay[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign w_next_time = r_time[i];
            assign w_next_pay  = r_pay[i];
        end else begin : g_inner
            assign w_next_time = r_time[i+1];
            assign w_next_pay  = r_pay[i+1];
        end
        assign w_take_new = w_gt[i] || (CNT_W'(i) == r_count);

        assign n_time[i] = !i_cmd.insert ? w_next_time :
                           w_from_prev   ? w_prev_time :
                           w_take_new    ? i_event_time : r_time[i];
        assign n_pay[i]  = !i_cmd.insert ? w_next_pay :
                           w_from_prev   ? w_prev_pay :
                           w_take_new    ? i_event_payload : r_pay[i];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert || i_cmd.pop) begin
            r_time <= n_time;
            r_pay  <= n_pay;
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.insert) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // dump context, captured when a dump word is taken with tracing on
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_all   <= i_force_all | r_drain_all;
            r_limit <= i_dump_limit;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_reject || i_cmd.load_empty || i_cmd.pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_status   <= ST_DRAINED;
            r_out_pay  <= r_pay[0];
            r_out_time <= r_time[0];
            r_last     <= ~o_stat.next_ok;
        end else if (i_cmd.load_reject || i_cmd.load_empty) begin
            r_status   <= i_cmd.load_reject ? ST_FULL : ST_EMPTY;
            r_out_pay  <= '0;
            r_out_time <= '0;
            r_last     <= 1'b1;
        end
    end

    // status toward the controller
    always_comb begin
        o_stat.full     = (r_count == CNT_W'(DEPTH));
        o_stat.trace_en = r_trace_en;
        o_stat.head_ok  = (r_count != '0) && (r_all || (r_time[0] <= r_limit));
        o_stat.next_ok  = (r_count > CNT_W'(1)) && (r_all || (r_time[1] <= r_limit));
        o_stat.out_free = ~r_out_valid | i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_payload = r_out_pay;
    assign o_out_time    = r_out_time;
    assign o_last        = r_last;

endmodule

/* rtl/toeb_ctrl.sv */
// ----------------------------------------------------------------------------
// toeb_ctrl
// Controller: takes input words; dumps one event per cycle unless stalled.
// ----------------------------------------------------------------------------
module toeb_ctrl
    import toeb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_op,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    if (i_op == OP_INSERT) begin
                        if (i_stat.full) o_cmd.load_reject = 1'b1;
                        else             o_cmd.insert      = 1'b1;
                    end else if (!i_stat.trace_en) begin
                        o_cmd.load_empty = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_DUMP;
                    end
                end
            end
            S_DUMP: begin
                // head can be not drainable only before the first pop of a dump
                if (i_stat.out_free) begin
                    if (i_stat.head_ok) begin
                        o_cmd.pop = 1'b1;
                        if (!i_stat.next_ok) n_state = S_IDLE;
                    end else begin
                        o_cmd.load_empty = 1'b1;
                        n_state          = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/timestamp_ordered_event_buffer.sv */
// ----------------------------------------------------------------------------
// timestamp_ordered_event_buffer
// Sorted-insertion event queue keyed by 48-bit timestamp, drained in order.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries insert words (op 0: event_time, event_payload) and dump
//   words (op 1: force_all, dump_limit). o_out carries result words with
//   status, out_payload, out_time and last. i_cfg writes trace_enabled
//   (index 0) and drain_all_mode (index 1); it is always ready.
//   A successful insert gives no result; equal timestamps keep arrival
//   order. An insert into a full buffer gives one registered status-2
//   word. A dump first captures the limit, then shifts its events out of
//   the head cell one event per cycle while the receiver does not stall,
//   the last one flagged. A dump that drains nothing, or any dump with
//   tracing off, gives one status-1 word.
//   Input is taken one word at a time; none is taken while a dump runs.
//   The single result register sets the pace: when the receiver stalls, the
//   result holds and the dump waits, and no new word is taken while the
//   result register cannot be refilled.
//   Reset empties the buffer, sets tracing on and drain-all mode off.
// ----------------------------------------------------------------------------
module timestamp_ordered_event_buffer
    import toeb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    toeb_in_if.sink    i_in,
    toeb_out_if.source o_out,
    toeb_cfg_if.sink   i_cfg
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign i_cfg.ready = 1'b1;

    toeb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_op       (i_in.op),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    toeb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_event_time    (i_in.event_time),
        .i_event_payload (i_in.event_payload),
        .i_force_all     (i_in.force_all),
        .i_dump_limit    (i_in.dump_limit),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_status        (o_out.status),
        .o_out_payload   (o_out.out_payload),
        .o_out_time      (o_out.out_time),
        .o_last          (o_out.last)
    );

endmodule

/* rtl/toeb_checker.sv */
// ----------------------------------------------------------------------------
// toeb_checker
// Port-level checks of the event buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "timestamp_ordered_event_buffer_assert.svh"

module toeb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [31:0] i_out_payload,
    input logic [47:0] i_out_time,
    input logic        i_last
);

    // a stalled result word holds its status, payload and time
    `TOEB_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_status) && $stable(i_out_payload) && $stable(i_out_time))

    // status code 3 is never produced
    `TOEB_ASSERT_NOW(a_status_code, i_out_valid, i_status != 2'd3)

    // empty and full words are single, zero-filled results
    `TOEB_ASSERT_NOW(a_status_word, i_out_valid && (i_status != 2'd0),
        i_last && (i_out_payload == 32'd0) && (i_out_time == 48'd0))

    // no input word is taken while a dump still has events to send
    `TOEB_ASSERT_NOW(a_dump_busy, i_out_valid && !i_last, !i_in_ready)

endmodule

bind timestamp_ordered_event_buffer toeb_checker u_toeb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_out_payload (o_out.out_payload),
    .i_out_time    (o_out.out_time),
    .i_last        (o_out.last)
);
